// ----- sv/pal_pkg.sv -----
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, sizes and conversion helpers for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  // list geometry
  localparam int CAPACITY   = 8;
  localparam int DATA_WIDTH = 32;

  // counter holds 0..CAPACITY, index addresses 0..CAPACITY-1
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // width for comparing a position against the count
  localparam int CMP_W = ((CNT_W > 4) ? CNT_W : 4) + 1;

  // port-facing field widths
  localparam int CMD_W    = 2;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  // what a slot cell does at each clock edge
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_TAKE_LEFT,
    OP_TAKE_RIGHT,
    OP_LOAD,
    OP_ZERO
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  // stored slot to 32-bit port value, sign-extended
  function automatic logic [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[VAL_W-1:0];
  endfunction

  // 32-bit port value to slot width, sign-extended then trimmed
  function automatic logic [DATA_WIDTH-1:0] from_in(input logic [VAL_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[DATA_WIDTH-1:0];
  endfunction

endpackage

// ----- sv/pal_cell.sv -----
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds its entry or takes it from a neighbor, the new item
// value, or zero, as the control word says.
// ----------------------------------------------------------------------------
module pal_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pal_pkg::cell_ctrl_t             ctrl_i,
  input  logic [pal_pkg::DATA_WIDTH-1:0]  left_i,
  input  logic [pal_pkg::DATA_WIDTH-1:0]  right_i,
  input  logic [pal_pkg::DATA_WIDTH-1:0]  load_i,
  output logic [pal_pkg::DATA_WIDTH-1:0]  slot_o
);

  logic [pal_pkg::DATA_WIDTH-1:0] slot_q, slot_d;

  // next slot value
  always_comb begin
    case (ctrl_i.op)
      pal_pkg::OP_TAKE_LEFT:  slot_d = left_i;
      pal_pkg::OP_TAKE_RIGHT: slot_d = right_i;
      pal_pkg::OP_LOAD:       slot_d = load_i;
      pal_pkg::OP_ZERO:       slot_d = '0;
      default:                slot_d = slot_q;
    endcase
  end

  // slot register, store resets to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ----- sv/positional_array_list.sv -----
// ----------------------------------------------------------------------------
// positional_array_list
// Fixed-capacity ordered list with 1-based positions, built as a row of slot
// cells that shift toward or away from their neighbors on insert and delete.
// ----------------------------------------------------------------------------
//  channel  | handshake              | fields
//  ---------+------------------------+---------------------------------------
//  command  | start_i, busy_o        | cmd_i, position_i, item_value_i
//  result   | valid_o (strobe)       | status_o, out_value_o, entry_count_o,
//           |                        | is_full_o, is_empty_o
//
// Every item is handled at once: all cells update in parallel at the accepting
// edge and valid_o marks the result in the next cycle, for that cycle only.
// busy_o stays low, so a new item may come in every cycle.
// Reset zeroes every slot and the count at once; no clearing pass.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module positional_array_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [pal_pkg::CMD_W-1:0]     cmd_i,
  input  logic [pal_pkg::POS_W-1:0]     position_i,
  input  logic [pal_pkg::VAL_W-1:0]     item_value_i,
  output logic                          valid_o,
  output logic [pal_pkg::STATUS_W-1:0]  status_o,
  output logic [pal_pkg::VAL_W-1:0]     out_value_o,
  output logic [pal_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                          is_full_o,
  output logic                          is_empty_o
);

  localparam int CAP = pal_pkg::CAPACITY;
  localparam int DW  = pal_pkg::DATA_WIDTH;
  localparam int CW  = pal_pkg::CMP_W;

  logic                       accept;
  pal_pkg::cmd_e              cmd;
  logic [pal_pkg::CNT_W-1:0]  count_q, count_d;
  logic [CW-1:0]              pos_ext, cnt_ext, pidx;
  logic                       full_now, empty_now, pos_ok_ins, pos_ok_rd;
  logic                       do_ins, do_del;
  pal_pkg::status_e           status_d, status_q;
  logic [pal_pkg::VAL_W-1:0]  value_d, value_q;
  logic [DW-1:0]              load_val;
  logic [DW-1:0]              slot [CAP];
  pal_pkg::cell_ctrl_t        ctrl [CAP];
  logic                       valid_q, full_q, empty_q;
  logic [CW-1:0]              cnt_next_ext;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign cmd    = pal_pkg::cmd_e'(cmd_i);

  // position checks against the current count
  assign pos_ext    = CW'(position_i);
  assign cnt_ext    = CW'(count_q);
  assign pidx       = pos_ext - CW'(1);
  assign full_now   = (cnt_ext == CW'(CAP));
  assign empty_now  = (count_q == '0);
  assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CW'(1));
  assign pos_ok_rd  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign load_val   = pal_pkg::from_in(item_value_i);

  // status, returned value and next count
  always_comb begin
    status_d = pal_pkg::ST_OK;
    value_d  = '0;
    count_d  = count_q;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    case (cmd)
      pal_pkg::CMD_INSERT: begin
        if (full_now) begin
          status_d = pal_pkg::ST_OVERFLOW;
        end else if (!pos_ok_ins) begin
          status_d = pal_pkg::ST_INVALID;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + pal_pkg::CNT_W'(1);
        end
      end
      pal_pkg::CMD_DELETE: begin
        if (empty_now) begin
          status_d = pal_pkg::ST_UNDERFLOW;
        end else if (!pos_ok_rd) begin
          status_d = pal_pkg::ST_INVALID;
        end else begin
          do_del  = 1'b1;
          value_d = pal_pkg::to_out(slot[pidx[pal_pkg::IDX_W-1:0]]);
          count_d = count_q - pal_pkg::CNT_W'(1);
        end
      end
      pal_pkg::CMD_READ: begin
        if (!pos_ok_rd) begin
          status_d = pal_pkg::ST_INVALID;
        end else begin
          value_d = pal_pkg::to_out(slot[pidx[pal_pkg::IDX_W-1:0]]);
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  // per-cell control: zero all on clear, shift up from the insert point, down from the delete point
  always_comb begin
    for (int j = 0; j < CAP; j++) begin
      ctrl[j].op = pal_pkg::OP_HOLD;
      if (accept) begin
        if (cmd == pal_pkg::CMD_CLEAR) begin
          ctrl[j].op = pal_pkg::OP_ZERO;
        end else if (do_ins) begin
          if (CW'(j) == pidx) begin
            ctrl[j].op = pal_pkg::OP_LOAD;
          end else if ((CW'(j) > pidx) && (CW'(j) <= cnt_ext)) begin
            ctrl[j].op = pal_pkg::OP_TAKE_LEFT;
          end
        end else if (do_del) begin
          if (CW'(j) + CW'(1) == cnt_ext) begin
            ctrl[j].op = pal_pkg::OP_ZERO;
          end else if ((CW'(j) >= pidx) && (CW'(j) + CW'(1) < cnt_ext)) begin
            ctrl[j].op = pal_pkg::OP_TAKE_RIGHT;
          end
        end
      end
    end
  end

  // row of slot cells
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = slot[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = slot[g+1];
    end
    pal_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .load_i  (load_val),
      .slot_o  (slot[g])
    );
  end

  assign cnt_next_ext = CW'(count_d);

  // count and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      full_q   <= (cnt_next_ext == CW'(CAP));
      empty_q  <= (count_d == '0);
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign out_value_o   = value_q;
  assign entry_count_o = pal_pkg::COUNT_W'(count_q);
  assign is_full_o     = full_q;
  assign is_empty_o    = empty_q;

endmodule

// ----- sv/pal_checker.sv -----
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks on the positional array list, bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [pal_pkg::CMD_W-1:0]     cmd_i,
  input logic                          valid_o,
  input logic [pal_pkg::STATUS_W-1:0]  status_o,
  input logic                          is_full_o,
  input logic                          is_empty_o
);

  // every accepted item gives a strobe in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> valid_o)
    else $error("accepted item gave no result");

  // no strobe without an accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !valid_o)
    else $error("result without an accepted item");

  // clear always succeeds and leaves the list empty
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == pal_pkg::CMD_CLEAR) |=>
      (status_o == pal_pkg::ST_OK && is_empty_o && !is_full_o))
    else $error("clear did not empty the list");

  // overflow only on a full list, underflow only on an empty one
  a_flow_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((status_o != pal_pkg::ST_OVERFLOW || is_full_o) &&
                 (status_o != pal_pkg::ST_UNDERFLOW || is_empty_o)))
    else $error("overflow or underflow flag mismatch");

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .cmd_i      (cmd_i),
  .valid_o    (valid_o),
  .status_o   (status_o),
  .is_full_o  (is_full_o),
  .is_empty_o (is_empty_o)
);
